// ===== src/gcdlcm_pkg.sv =====
// shared types, constants and datapath operation codes for the gcd / lcm unit
package gcdlcm_pkg;

   // fixed field widths of the transaction payloads
   localparam int unsigned FIELD_WIDTH          = 16;
   localparam int unsigned LCM_WIDTH            = 32;
   localparam int unsigned OPERAND_WIDTH_DEFAULT = 16;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] first_operand;
      logic [FIELD_WIDTH-1:0] second_operand;
   } req_type;

   typedef struct packed {
      logic [LCM_WIDTH-1:0]   least_multiple;
      logic [FIELD_WIDTH-1:0] greatest_divisor;
      logic                   zero_operand_error;
   } rsp_type;

   // operation applied by the datapath in the current cycle
   typedef enum logic [4:0] {
      OP_HOLD = 5'b00001,
      OP_LOAD = 5'b00010,
      OP_GCD  = 5'b00100,
      OP_DIV  = 5'b01000,
      OP_MUL  = 5'b10000
   } op_type;

endpackage

// ===== src/gcdlcm_dpath.sv =====
// datapath: operand registers around one shared add / subtract unit
module gcdlcm_dpath #(
   parameter int unsigned DataWidth = gcdlcm_pkg::FIELD_WIDTH
) (
   input  logic                     clock,
   input  gcdlcm_pkg::op_type       op,
   input  logic [DataWidth-1:0]     load_a,
   input  logic [DataWidth-1:0]     load_b,
   output logic                     gcd_done,
   output logic [DataWidth-1:0]     gcd_out,
   output logic [2*DataWidth-1:0]   prod_out
);

   localparam int unsigned KWidth = $clog2(DataWidth);

   logic [DataWidth-1:0] x_ff, x_in;
   logic [DataWidth-1:0] y_ff, y_in;
   logic [KWidth-1:0]    k_ff, k_in;
   logic [DataWidth-1:0] g_ff, g_in;
   logic [DataWidth-1:0] rem_ff, rem_in;
   logic [DataWidth-1:0] quo_ff, quo_in;
   logic [DataWidth-1:0] acc_ff, acc_in;
   logic [DataWidth-1:0] b_ff, b_in;

   // shared unit
   logic [DataWidth+1:0] unit_a, unit_b, unit_res;
   logic                 unit_sub;

   always_comb begin
      unit_a   = '0;
      unit_b   = '0;
      unit_sub = 1'b0;
      case (op)
         gcdlcm_pkg::OP_GCD: begin
            unit_a   = {2'b00, x_ff};
            unit_b   = {2'b00, y_ff};
            unit_sub = 1'b1;
         end
         gcdlcm_pkg::OP_DIV: begin
            unit_a   = {1'b0, rem_ff, quo_ff[DataWidth-1]};
            unit_b   = {2'b00, g_ff};
            unit_sub = 1'b1;
         end
         gcdlcm_pkg::OP_MUL: begin
            unit_a   = {2'b00, acc_ff};
            unit_b   = quo_ff[0] ? {2'b00, b_ff} : '0;
            unit_sub = 1'b0;
         end
         default: begin
            unit_sub = 1'b0;
         end
      endcase
   end

   assign unit_res = unit_a + (unit_sub ? ~unit_b : unit_b) + (DataWidth+2)'(unit_sub);

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      k_in   = k_ff;
      g_in   = g_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      acc_in = acc_ff;
      b_in   = b_ff;
      case (op)
         gcdlcm_pkg::OP_LOAD: begin
            x_in   = load_a;
            y_in   = load_b;
            k_in   = '0;
            rem_in = '0;
            acc_in = '0;
            quo_in = load_a;
            b_in   = load_b;
         end
         gcdlcm_pkg::OP_GCD: begin
            if (x_ff == '0) begin
               g_in = y_ff << k_ff;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (unit_res[DataWidth+1]) begin
               // x below y: swap so the next subtract stays positive
               x_in = y_ff;
               y_in = x_ff;
            end else begin
               x_in = unit_res[DataWidth-1:0];
            end
         end
         gcdlcm_pkg::OP_DIV: begin
            if (!unit_res[DataWidth+1]) begin
               rem_in = unit_res[DataWidth-1:0];
            end else begin
               rem_in = unit_a[DataWidth-1:0];
            end
            quo_in = {quo_ff[DataWidth-2:0], ~unit_res[DataWidth+1]};
         end
         gcdlcm_pkg::OP_MUL: begin
            acc_in = unit_res[DataWidth:1];
            quo_in = {unit_res[0], quo_ff[DataWidth-1:1]};
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      k_ff   <= k_in;
      g_ff   <= g_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      acc_ff <= acc_in;
      b_ff   <= b_in;
   end

   assign gcd_done = (x_ff == '0);
   assign gcd_out  = g_ff;
   assign prod_out = {acc_ff, quo_ff};

endmodule

// ===== src/gcdlcm_ctrl.sv =====
// sequencer: steps the datapath through gcd, divide and multiply phases
module gcdlcm_ctrl #(
   parameter int unsigned DataWidth = gcdlcm_pkg::FIELD_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic               gcd_done,
   output gcdlcm_pkg::op_type op,
   output logic               busy,
   output logic               finish
);

   localparam int unsigned CntWidth = $clog2(DataWidth);
   localparam logic [CntWidth-1:0] CntLast = CntWidth'(DataWidth - 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_GCD  = 5'b00010,
      S_DIV  = 5'b00100,
      S_MUL  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op       = gcdlcm_pkg::OP_HOLD;
      case (state_ff)
         S_IDLE: begin
            if (go) begin
               op       = gcdlcm_pkg::OP_LOAD;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            op = gcdlcm_pkg::OP_GCD;
            if (gcd_done) begin
               cnt_in   = CntLast;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            op = gcdlcm_pkg::OP_DIV;
            if (cnt_ff == '0) begin
               cnt_in   = CntLast;
               state_in = S_MUL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_MUL: begin
            op = gcdlcm_pkg::OP_MUL;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy   = (state_ff != S_IDLE);
   assign finish = (state_ff == S_DONE);

endmodule

// ===== src/gcd_lcm_unit.sv =====
// top level of the gcd / lcm unit: handshake, zero check and result register
//
// computes the greatest common divisor and least common multiple of two
// unsigned operands (each masked to OPERAND_WIDTH bits, at most the 16 field
// bits). a transaction is taken when start is high and busy is low. the gcd
// comes from a binary (shift and subtract) algorithm, then the first operand
// is divided by it with a restoring divider and the quotient multiplied by
// the second operand shift-and-add; all three phases share one add/subtract
// unit, and busy stays high while they run. a zero operand skips the
// arithmetic: the error result appears the cycle after the transaction. each
// result is shown for exactly one cycle with rsp_valid high and cannot be
// stalled; a new transaction may be taken while that result is on the ports.
module gcd_lcm_unit #(
   parameter int unsigned OPERAND_WIDTH = gcdlcm_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  gcdlcm_pkg::req_type req_data,
   output logic                rsp_valid,
   output gcdlcm_pkg::rsp_type rsp_data
);

   // effective width: the operand fields carry 16 bits at most
   localparam int unsigned CoreWidth =
      (OPERAND_WIDTH < gcdlcm_pkg::FIELD_WIDTH) ? OPERAND_WIDTH : gcdlcm_pkg::FIELD_WIDTH;

   logic [CoreWidth-1:0]   a_val, b_val;
   logic                   zero_op;
   logic                   accept;
   logic                   go;
   gcdlcm_pkg::op_type     op;
   logic                   gcd_done;
   logic                   finish;
   logic [CoreWidth-1:0]   gcd_val;
   logic [2*CoreWidth-1:0] prod_val;

   logic                rsp_valid_ff, rsp_valid_in;
   gcdlcm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // operands masked to the configured width
   assign a_val   = req_data.first_operand[CoreWidth-1:0];
   assign b_val   = req_data.second_operand[CoreWidth-1:0];
   assign zero_op = (a_val == '0) || (b_val == '0);

   // transaction taken; zero operands never enter the sequencer
   assign accept = start && !busy;
   assign go     = accept && !zero_op;

   gcdlcm_ctrl #(
      .DataWidth (CoreWidth)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .gcd_done (gcd_done),
      .op       (op),
      .busy     (busy),
      .finish   (finish)
   );

   gcdlcm_dpath #(
      .DataWidth (CoreWidth)
   ) u_dpath (
      .clock    (clock),
      .op       (op),
      .load_a   (a_val),
      .load_b   (b_val),
      .gcd_done (gcd_done),
      .gcd_out  (gcd_val),
      .prod_out (prod_val)
   );

   // result register: error results straight from the accept, others at finish
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      if (accept && zero_op) begin
         rsp_valid_in                   = 1'b1;
         rsp_data_in.least_multiple     = '0;
         rsp_data_in.greatest_divisor   = '0;
         rsp_data_in.zero_operand_error = 1'b1;
      end else if (finish) begin
         rsp_valid_in                   = 1'b1;
         rsp_data_in.least_multiple     = gcdlcm_pkg::LCM_WIDTH'(prod_val);
         rsp_data_in.greatest_divisor   = gcdlcm_pkg::FIELD_WIDTH'(gcd_val);
         rsp_data_in.zero_operand_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a zero operand gives an error result on the next cycle
   a_zero_error: assert property (@(posedge clock) disable iff (reset)
      accept && zero_op |=> rsp_valid && rsp_data.zero_operand_error)
      else $error("zero operand transaction did not produce an error result");

   // a good transaction keeps the unit busy
   a_busy_after_go: assert property (@(posedge clock) disable iff (reset)
      go |=> busy)
      else $error("unit not busy after taking a transaction");

   // a valid non-error result never has a zero gcd
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.zero_operand_error |-> rsp_data.greatest_divisor != '0)
      else $error("zero gcd on a non-error result");

   // non-error results only follow the end of a sequence
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.zero_operand_error |-> $past(finish))
      else $error("result strobe without a finished sequence");

endmodule

// ===== tb/tb_gcd_lcm_unit.sv =====
// self-checking testbench for the gcd / lcm unit: directed and random operand transactions
`timescale 1ns / 1ps

module tb_gcd_lcm_unit;

   localparam int unsigned OPER_W        = gcdlcm_pkg::OPERAND_WIDTH_DEFAULT;
   localparam int          CLOCK_PERIOD  = 8;
   localparam int          RANDOM_ITEMS  = 2000;
   // the last stretch of random transactions is sent back to back
   localparam int          STEADY_ITEMS  = 300;
   localparam int          DRAIN_CYCLES  = 2000;
   localparam int          TAIL_CYCLES   = 150;
   localparam int          RUN_LIMIT_NS  = 20_000_000;

   // one outstanding transaction: the operands and the result they must give
   typedef struct {
      gcdlcm_pkg::req_type operands;
      gcdlcm_pkg::rsp_type result;
   } pending_type;

   // keeps the expected gcd / lcm results in order and checks what comes out
   class gcd_lcm_ledger_type;
      pending_type  pending_results[$];
      logic [15:0]  operand_mask;
      int           mismatches;
      int           results_checked;
      int           zero_cases;
      int           accepted;

      function new(int unsigned width);
         operand_mask    = (width >= 16) ? 16'hFFFF : 16'((32'd1 << width) - 1);
         mismatches      = 0;
         results_checked = 0;
         zero_cases      = 0;
         accepted        = 0;
      endfunction

      // euclid for the gcd, then (a / g) * b for the lcm, truncated to the fields
      function gcdlcm_pkg::rsp_type predict_gcd_lcm(gcdlcm_pkg::req_type operands);
         longint unsigned     a, b, x, y, r, lcm;
         gcdlcm_pkg::rsp_type res;
         a = 64'(operands.first_operand & operand_mask);
         b = 64'(operands.second_operand & operand_mask);
         res = '0;
         if (a == 0 || b == 0) begin
            res.zero_operand_error = 1'b1;
         end else begin
            x = a;
            y = b;
            while (y != 0) begin
               r = x % y;
               x = y;
               y = r;
            end
            lcm = (a / x) * b;
            res.least_multiple   = lcm[gcdlcm_pkg::LCM_WIDTH-1:0];
            res.greatest_divisor = x[gcdlcm_pkg::FIELD_WIDTH-1:0];
         end
         return res;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      function void note_request(gcdlcm_pkg::req_type operands);
         pending_type entry;
         entry.operands = operands;
         entry.result   = predict_gcd_lcm(operands);
         if (entry.result.zero_operand_error)
            zero_cases++;
         accepted++;
         pending_results.push_back(entry);
      endfunction

      task check_result(gcdlcm_pkg::rsp_type got);
         pending_type want;
         string       tag;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result lcm=%0d gcd=%0d err=%0b with nothing outstanding",
                                      got.least_multiple, got.greatest_divisor,
                                      got.zero_operand_error));
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            tag  = $sformatf("a=%0d b=%0d", want.operands.first_operand,
                             want.operands.second_operand);
            if (got.least_multiple !== want.result.least_multiple)
               report_mismatch($sformatf("%s least_multiple got %0d want %0d", tag,
                                         got.least_multiple, want.result.least_multiple));
            if (got.greatest_divisor !== want.result.greatest_divisor)
               report_mismatch($sformatf("%s greatest_divisor got %0d want %0d", tag,
                                         got.greatest_divisor, want.result.greatest_divisor));
            if (got.zero_operand_error !== want.result.zero_operand_error)
               report_mismatch($sformatf("%s zero_operand_error got %0b want %0b", tag,
                                         got.zero_operand_error,
                                         want.result.zero_operand_error));
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   gcdlcm_pkg::req_type req_data;
   logic                rsp_valid;
   gcdlcm_pkg::rsp_type rsp_data;

   gcd_lcm_ledger_type ledger = new(OPER_W);

   gcd_lcm_unit #(
      .OPERAND_WIDTH(OPER_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // monitor: samples pre-edge values, so results are taken before new transactions
   // (a new transaction may be accepted on the edge that ends a result cycle)
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            ledger.check_result(rsp_data);
         if (start && !busy)
            ledger.note_request(req_data);
      end
   end

   // present one transaction at the falling edge and hold it until busy is low at a rising edge
   task automatic send_operands(logic [15:0] a, logic [15:0] b);
      @(negedge clock);
      start                   <= 1'b1;
      req_data.first_operand  <= a;
      req_data.second_operand <= b;
      do
         @(posedge clock);
      while (busy);
   endtask

   // sender idles; the payload carries junk that must be ignored
   task automatic idle_sender(int cycles);
      @(negedge clock);
      start    <= 1'b0;
      req_data <= gcdlcm_pkg::req_type'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   // hold off new transactions until every expected result has come back
   task automatic wait_for_drain();
      int waited;
      waited = 0;
      @(negedge clock);
      start <= 1'b0;
      while (ledger.pending_results.size() != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // random operand pairs, weighted towards shared factors and the corner regions
   task automatic send_random_operands();
      int          sel;
      int unsigned common;
      logic [15:0] a, b;
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
         // zero operand on one side (both only by chance)
         a = (sel < 2) ? 16'd0 : 16'($urandom);
         b = (sel >= 2 && sel < 4) ? 16'd0 : 16'($urandom);
         if (sel == 4) a = 16'd0;
      end else if (sel < 35) begin
         // a large common divisor so the gcd is far from one
         common = $urandom_range(1, 255);
         a = 16'(common * $urandom_range(1, 65535 / common));
         b = 16'(common * $urandom_range(1, 65535 / common));
      end else if (sel < 45) begin
         a = 16'($urandom_range(1, 64));
         b = 16'($urandom_range(1, 64));
      end else if (sel < 50) begin
         a = 16'($urandom);
         b = a;
      end else if (sel < 55) begin
         // one operand divides the other
         a = 16'($urandom_range(1, 255));
         b = 16'(a * $urandom_range(1, 65535 / a));
         if ($urandom_range(0, 1)) {a, b} = {b, a};
      end else begin
         a = 16'($urandom);
         b = 16'($urandom);
      end
      send_operands(a, b);
   endtask

   initial begin
      logic [15:0] corner_pairs [$];
      int          idx;
      int          tail;

      clock    = 1'b0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;

      // synchronous reset held from time zero, released at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part: zero operands, field extremes, equal operands, primes,
      // a largest lcm that still fits, alternating bit patterns
      corner_pairs = '{16'd0,     16'd0,
                       16'd0,     16'd5,
                       16'd7,     16'd0,
                       16'd0,     16'hFFFF,
                       16'hFFFF,  16'd0,
                       16'd1,     16'd1,
                       16'hFFFF,  16'hFFFF,
                       16'hFFFF,  16'hFFFE,
                       16'd1,     16'hFFFF,
                       16'hFFFF,  16'd1,
                       16'd12,    16'd18,
                       16'd48,    16'd180,
                       16'h8000,  16'h8000,
                       16'h8000,  16'd1024,
                       16'd65521, 16'd65519,
                       16'd5,     16'd5,
                       16'd1,     16'd2,
                       16'd2,     16'd1,
                       16'd40320, 16'd5040,
                       16'h5555,  16'hAAAA,
                       16'hAAAA,  16'h5555,
                       16'hFFFE,  16'h8000,
                       16'd17,    16'd51};
      for (idx = 0; idx < corner_pairs.size(); idx += 2) begin
         send_operands(corner_pairs[idx], corner_pairs[idx + 1]);
         if (idx % 6 == 4)
            idle_sender($urandom_range(1, 15));
      end
      wait_for_drain();

      // random part: bursts of idling early on, none in the last stretch
      for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
         if (idx == RANDOM_ITEMS / 2)
            wait_for_drain();
         send_random_operands();
         if (idx < RANDOM_ITEMS - STEADY_ITEMS && $urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 15));
      end

      // let the last results come out, then watch for strays
      wait_for_drain();
      for (tail = 0; tail < TAIL_CYCLES; tail++)
         @(posedge clock);
      while (ledger.pending_results.size() != 0) begin
         void'(ledger.pending_results.pop_front());
         ledger.report_mismatch("expected result never arrived");
      end

      $display("covered %0d transactions (%0d with a zero operand), %0d results checked",
               ledger.accepted, ledger.zero_cases, ledger.results_checked);
      $display("directed corners, shared-factor, divisor and full-range random operands");
      if (ledger.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog for a hung handshake
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout after %0d ns", RUN_LIMIT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/gcdlcm_pkg.sv
src/gcdlcm_dpath.sv
src/gcdlcm_ctrl.sv
src/gcd_lcm_unit.sv
tb/tb_gcd_lcm_unit.sv
